// ===== rtl/ndef_tlv_pkg.sv =====
// Types and constants shared by the NDEF TLV stream parser.
`default_nettype none

package ndef_tlv_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] LONG_LEN_MARK = 8'hFF;
    localparam logic [BYTE_W-1:0] NULL_RST      = 8'h00;
    localparam logic [BYTE_W-1:0] TERM_RST      = 8'hFE;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NULL_TYPE = 8'd0,
        REG_TERM_TYPE = 8'd1
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE = 3'd0,
        KIND_EMPTY = 3'd1,
        KIND_TERM  = 3'd2,
        KIND_TRUNC = 3'd3,
        KIND_EOF   = 3'd4
    } kind_t;

    typedef enum logic [5:0] {
        PH_TYPE   = 6'b000001,
        PH_LEN    = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_LEN_LO = 6'b001000,
        PH_VALUE  = 6'b010000,
        PH_SKIP   = 6'b100000
    } phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] tlv_type;
        logic [BYTE_W-1:0] value_byte;
        logic [LEN_W-1:0]  tlv_length;
        logic              first_of_value;
        logic              last_of_value;
        logic              last_result;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/ndef_tlv_stream_parser.sv =====
// Top level of the NDEF TLV stream parser: byte-wise header decode and result queue.
// Results are registered in the result queue; its head drives the master side.
// Throughput: one input beat per cycle while the four-entry result queue has room for two
// results; an input beat makes at most two results, so rate is set by the queue drain.
// Reset: rst_n is asynchronous, active low; it empties the queue, returns the parser to
// expecting a type byte and restores the padding and terminator codes to 0x00 and 0xFE.
`default_nettype none

module ndef_tlv_stream_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Byte stream in.
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_data
    // Result stream out.
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [39:0] m_axis_tdata,   // [7:0] tlv_type, [15:8] value_byte,
                                             // [31:16] tlv_length, [32] first_of_value,
                                             // [33] last_of_value, [39:34] zero
    output      logic [2:0]  m_axis_tuser,   // [2:0] kind
    output      logic        m_axis_tlast    // last_result
);

    // Configuration registers. The port never stalls.
    logic [ndef_tlv_pkg::BYTE_W-1:0] null_code_reg;
    logic [ndef_tlv_pkg::BYTE_W-1:0] term_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_code_reg <= ndef_tlv_pkg::NULL_RST;
            term_code_reg <= ndef_tlv_pkg::TERM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ndef_tlv_pkg::REG_NULL_TYPE: null_code_reg <= cfg_data;
                ndef_tlv_pkg::REG_TERM_TYPE: term_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state.
    ndef_tlv_pkg::phase_t            phase_reg,     phase_next;
    logic [ndef_tlv_pkg::BYTE_W-1:0] cur_type_reg,  cur_type_next;
    logic [ndef_tlv_pkg::LEN_W-1:0]  decl_len_reg,  decl_len_next;
    logic [ndef_tlv_pkg::LEN_W-1:0]  remain_reg,    remain_next;
    logic [ndef_tlv_pkg::BYTE_W-1:0] len_hi_reg,    len_hi_next;

    // Result queue: a small ring that can take two results in one cycle.
    ndef_tlv_pkg::result_t          fifo_mem [ndef_tlv_pkg::FIFO_DEPTH];
    logic [ndef_tlv_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ndef_tlv_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ndef_tlv_pkg::CNT_W-1:0] count_reg,  count_next;

    logic                  in_fire;
    logic                  out_fire;
    logic                  has_a;
    logic                  has_b;
    ndef_tlv_pkg::result_t res_a;
    ndef_tlv_pkg::result_t res_b;
    ndef_tlv_pkg::result_t slot0;
    logic [ndef_tlv_pkg::LEN_W-1:0] len_done;
    logic                  use_len_done;
    logic [ndef_tlv_pkg::CNT_W-1:0] push_cnt;

    // Accept only when two free slots are guaranteed, so a beat is never dropped.
    assign s_axis_tready = (count_reg <= ndef_tlv_pkg::CNT_W'(ndef_tlv_pkg::FIFO_DEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    // One byte of parsing. Result A comes from the phase itself; result B is the
    // frame-end result (truncated or end of frame) when the byte carries tlast.
    always_comb
    begin
        phase_next    = phase_reg;
        cur_type_next = cur_type_reg;
        decl_len_next = decl_len_reg;
        remain_next   = remain_reg;
        len_hi_next   = len_hi_reg;
        has_a         = 1'b0;
        res_a         = '0;
        res_b         = '0;
        len_done      = '0;
        use_len_done  = 1'b0;

        case (phase_reg)
            ndef_tlv_pkg::PH_TYPE:
            begin
                if (s_axis_tdata == null_code_reg)
                begin
                    // Padding byte: nothing happens.
                end
                else if (s_axis_tdata == term_code_reg)
                begin
                    has_a          = 1'b1;
                    res_a.kind     = ndef_tlv_pkg::KIND_TERM;
                    res_a.tlv_type = s_axis_tdata;
                    phase_next     = ndef_tlv_pkg::PH_SKIP;
                end
                else
                begin
                    cur_type_next = s_axis_tdata;
                    decl_len_next = '0;
                    remain_next   = '0;
                    phase_next    = ndef_tlv_pkg::PH_LEN;
                end
            end
            ndef_tlv_pkg::PH_LEN:
            begin
                if (s_axis_tdata == ndef_tlv_pkg::LONG_LEN_MARK)
                begin
                    phase_next = ndef_tlv_pkg::PH_LEN_HI;
                end
                else
                begin
                    use_len_done = 1'b1;
                    len_done     = {{(ndef_tlv_pkg::LEN_W - ndef_tlv_pkg::BYTE_W){1'b0}},
                                    s_axis_tdata};
                end
            end
            ndef_tlv_pkg::PH_LEN_HI:
            begin
                len_hi_next = s_axis_tdata;
                phase_next  = ndef_tlv_pkg::PH_LEN_LO;
            end
            ndef_tlv_pkg::PH_LEN_LO:
            begin
                use_len_done = 1'b1;
                len_done     = {len_hi_reg, s_axis_tdata};
            end
            ndef_tlv_pkg::PH_VALUE:
            begin
                has_a                = 1'b1;
                res_a.kind           = ndef_tlv_pkg::KIND_VALUE;
                res_a.tlv_type       = cur_type_reg;
                res_a.value_byte     = s_axis_tdata;
                res_a.tlv_length     = decl_len_reg;
                res_a.first_of_value = (remain_reg == decl_len_reg);
                res_a.last_of_value  = (remain_reg <= ndef_tlv_pkg::LEN_W'(1));
                remain_next          = remain_reg - ndef_tlv_pkg::LEN_W'(1);
                if (res_a.last_of_value)
                begin
                    phase_next = ndef_tlv_pkg::PH_TYPE;
                end
            end
            ndef_tlv_pkg::PH_SKIP:
            begin
                // Everything after a terminator is ignored until the frame ends.
            end
            default:
            begin
                phase_next = ndef_tlv_pkg::PH_TYPE;
            end
        endcase

        // A completed length either opens the value or closes an empty TLV.
        if (use_len_done)
        begin
            decl_len_next = len_done;
            if (len_done == '0)
            begin
                has_a          = 1'b1;
                res_a.kind     = ndef_tlv_pkg::KIND_EMPTY;
                res_a.tlv_type = cur_type_reg;
                phase_next     = ndef_tlv_pkg::PH_TYPE;
            end
            else
            begin
                remain_next = len_done;
                phase_next  = ndef_tlv_pkg::PH_VALUE;
            end
        end

        res_a.last_result = !s_axis_tlast;

        // Frame end: report a TLV left open, or a clean end, then start over.
        has_b             = s_axis_tlast;
        res_b.last_result = 1'b1;
        if (phase_next == ndef_tlv_pkg::PH_LEN || phase_next == ndef_tlv_pkg::PH_LEN_HI ||
            phase_next == ndef_tlv_pkg::PH_LEN_LO || phase_next == ndef_tlv_pkg::PH_VALUE)
        begin
            res_b.kind       = ndef_tlv_pkg::KIND_TRUNC;
            res_b.tlv_type   = cur_type_next;
            res_b.tlv_length = decl_len_next;
        end
        else
        begin
            res_b.kind = ndef_tlv_pkg::KIND_EOF;
        end

        if (s_axis_tlast)
        begin
            phase_next    = ndef_tlv_pkg::PH_TYPE;
            cur_type_next = '0;
            decl_len_next = '0;
            remain_next   = '0;
            len_hi_next   = '0;
        end
    end

    // Queue bookkeeping.
    always_comb
    begin
        slot0       = has_a ? res_a : res_b;
        push_cnt    = in_fire ? (ndef_tlv_pkg::CNT_W'(has_a) + ndef_tlv_pkg::CNT_W'(has_b))
                              : '0;
        wr_ptr_next = wr_ptr_reg + push_cnt[ndef_tlv_pkg::PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + ndef_tlv_pkg::PTR_W'(out_fire);
        count_next  = count_reg + push_cnt - ndef_tlv_pkg::CNT_W'(out_fire);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (has_a || has_b))
        begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (in_fire && has_a && has_b)
        begin
            fifo_mem[wr_ptr_reg + ndef_tlv_pkg::PTR_W'(1)] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ndef_tlv_pkg::PH_TYPE;
            cur_type_reg <= '0;
            decl_len_reg <= '0;
            remain_reg   <= '0;
            len_hi_reg   <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg    <= phase_next;
                cur_type_reg <= cur_type_next;
                decl_len_reg <= decl_len_next;
                remain_reg   <= remain_next;
                len_hi_reg   <= len_hi_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Head of the queue drives the master side.
    ndef_tlv_pkg::result_t head;

    assign head          = fifo_mem[rd_ptr_reg];
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last_result;
    assign m_axis_tdata  = {6'b0, head.last_of_value, head.first_of_value,
                            head.tlv_length, head.value_byte, head.tlv_type};

    // The queue never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ndef_tlv_pkg::CNT_W'(ndef_tlv_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A beat that ends the frame always leaves the parser expecting a type byte.
    a_frame_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_axis_tlast |=> phase_reg == ndef_tlv_pkg::PH_TYPE)
        else $error("parser not cleared after frame end");

    // While passing value bytes, the remaining count stays within the declared length.
    a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ndef_tlv_pkg::PH_VALUE |->
            remain_reg != '0 && remain_reg <= decl_len_reg)
        else $error("remaining byte count out of range");

    // A value beat always belongs to a TLV of nonzero length.
    a_value_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ndef_tlv_pkg::KIND_VALUE |->
            m_axis_tdata[31:16] != 16'd0)
        else $error("value beat with zero length");

endmodule

`default_nettype wire
